[sv/spx_pkg.sv]
// shared types and constants of the script signature / public key extractor
`default_nettype none
package spx_pkg;

    // script opcodes and marker bytes
    localparam logic [7:0] SPX_OP_PUSH_MAX  = 8'h4b;
    localparam logic [7:0] SPX_OP_PUSHDATA1 = 8'h4c;
    localparam logic [7:0] SPX_DER_SEQ      = 8'h30;
    localparam logic [7:0] SPX_DER_INT      = 8'h02;
    localparam logic [7:0] SPX_KEY_EVEN     = 8'h02;
    localparam logic [7:0] SPX_KEY_ODD      = 8'h03;
    localparam logic [7:0] SPX_KEY_FULL     = 8'h04;

    // length limits
    localparam logic [7:0] SPX_SIG_MIN      = 8'd9;
    localparam logic [7:0] SPX_SIG_MAX      = 8'd73;
    localparam logic [7:0] SPX_KEY_SHORT    = 8'd33;
    localparam logic [7:0] SPX_KEY_LONG     = 8'd65;

    // last chunk index of each key form, and byte counts of full and tail chunks
    localparam logic [3:0] SPX_LAST_SHORT   = 4'd4;
    localparam logic [3:0] SPX_LAST_LONG    = 4'd8;
    localparam logic [3:0] SPX_FULL_CHUNK   = 4'd8;
    localparam logic [3:0] SPX_TAIL_CHUNK   = 4'd1;

    // key store: two banks of sixteen 64-bit word slots
    localparam int SPX_WORD_W   = 64;
    localparam int SPX_RAM_DEPTH = 32;
    localparam int SPX_ADDR_W   = 5;

    typedef enum logic [2:0] {
        PH_SIG_OP,
        PH_SIG_LEN,
        PH_SIG_BODY,
        PH_KEY_OP,
        PH_KEY_LEN,
        PH_KEY_BODY,
        PH_IDLE
    } t_phase;

    typedef struct packed {
        logic                  en;
        logic [SPX_ADDR_W-1:0] addr;
        logic [SPX_WORD_W-1:0] data;
    } t_wr_req;

    typedef struct packed {
        logic valid;
        logic bank;
        logic long_key;
    } t_key_done;

    typedef struct packed {
        logic hold;
        logic busy;
    } t_em_status;

    typedef struct packed {
        logic [63:0] key_chunk;
        logic [3:0]  chunk_bytes;
        logic        last_chunk;
        logic [6:0]  key_length;
    } t_chunk;

endpackage
`default_nettype wire

[sv/spx_if.sv]
// stream interfaces for script bytes in and key chunks out
`default_nettype none
interface spx_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] script_byte;
    logic       end_of_script;

    modport source (output valid, output script_byte, output end_of_script, input ready);
    modport sink   (input valid, input script_byte, input end_of_script, output ready);
endinterface

interface spx_chunk_if;
    logic        valid;
    logic        ready;
    logic [63:0] key_chunk;
    logic [3:0]  chunk_bytes;
    logic        last_chunk;
    logic [6:0]  key_length;

    modport source (output valid, output key_chunk, output chunk_bytes,
                    output last_chunk, output key_length, input ready);
    modport sink   (input valid, input key_chunk, input chunk_bytes,
                    input last_chunk, input key_length, output ready);
endinterface
`default_nettype wire

[sv/spx_ram.sv]
// generic simple dual port ram with registered read
`default_nettype none
module spx_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

[sv/spx_parser.sv]
// script byte parser: push checks and key word assembly into the key store
`default_nettype none
module spx_parser (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    spx_byte_if.sink                i_byte_if,
    input  wire logic               i_hold,
    output spx_pkg::t_wr_req        o_wr,
    output spx_pkg::t_key_done      o_done
);
    import spx_pkg::*;

    t_phase      r_phase, n_phase;
    logic [7:0]  r_left, n_left;
    logic [7:0]  r_sig_len, n_sig_len;
    logic        r_key_long, n_key_long;
    logic        r_wr_bank, n_wr_bank;
    logic [63:0] r_word, n_word;

    logic        fire;
    logic [7:0]  b;
    logic [7:0]  sig_pos;
    logic [6:0]  key_len;
    logic [6:0]  key_pos;
    logic [2:0]  lane;
    logic [5:0]  shamt;
    logic [63:0] merged;
    logic        direct_push;
    logic        sig_len_ok;
    logic        key_len_ok;
    logic        key_len_long;
    logic        key_done;
    logic        key_write;

    assign i_byte_if.ready = !i_hold;
    assign fire            = i_byte_if.valid && i_byte_if.ready;
    assign b               = i_byte_if.script_byte;

    // positions within the current push
    assign sig_pos  = r_sig_len - r_left;
    assign key_len  = r_key_long ? SPX_KEY_LONG[6:0] : SPX_KEY_SHORT[6:0];
    assign key_pos  = key_len - r_left[6:0];
    assign lane     = key_pos[2:0];
    assign shamt    = {3'd7 - lane, 3'b000};
    assign merged   = (lane == 3'd0) ? {b, 56'd0} : (r_word | ({56'd0, b} << shamt));

    // push length decode; the direct push check is shared by both pushes
    assign direct_push  = (b != 8'd0) && (b <= SPX_OP_PUSH_MAX);
    assign sig_len_ok   = (b >= SPX_SIG_MIN) && (b <= SPX_SIG_MAX);
    assign key_len_ok   = (b == SPX_KEY_SHORT) || (b == SPX_KEY_LONG);
    assign key_len_long = (b == SPX_KEY_LONG);

    // next state
    always_comb begin
        n_phase    = r_phase;
        n_left     = r_left;
        n_sig_len  = r_sig_len;
        n_key_long = r_key_long;
        n_wr_bank  = r_wr_bank;
        n_word     = r_word;
        key_done   = 1'b0;
        key_write  = 1'b0;
        if (fire) begin
            case (r_phase)
                PH_SIG_OP, PH_SIG_LEN: begin
                    if (r_phase == PH_SIG_OP && b == SPX_OP_PUSHDATA1) begin
                        n_phase = PH_SIG_LEN;
                    end else if ((r_phase == PH_SIG_LEN || direct_push) && sig_len_ok) begin
                        n_sig_len = b;
                        n_left    = b;
                        n_phase   = PH_SIG_BODY;
                    end else begin
                        n_phase = PH_IDLE;
                    end
                end
                PH_SIG_BODY: begin
                    if ((sig_pos == 8'd0 && b != SPX_DER_SEQ) ||
                        (sig_pos == 8'd1 && b != r_sig_len - 8'd3) ||
                        (sig_pos == 8'd2 && b != SPX_DER_INT)) begin
                        n_phase = PH_IDLE;
                    end else begin
                        n_left = r_left - 8'd1;
                        if (r_left == 8'd1) begin
                            n_phase = PH_KEY_OP;
                        end
                    end
                end
                PH_KEY_OP, PH_KEY_LEN: begin
                    if (r_phase == PH_KEY_OP && b == SPX_OP_PUSHDATA1) begin
                        n_phase = PH_KEY_LEN;
                    end else if ((r_phase == PH_KEY_LEN || direct_push) && key_len_ok) begin
                        n_key_long = key_len_long;
                        n_left     = b;
                        n_phase    = PH_KEY_BODY;
                    end else begin
                        n_phase = PH_IDLE;
                    end
                end
                PH_KEY_BODY: begin
                    if (key_pos == 7'd0 &&
                        (r_key_long ? (b != SPX_KEY_FULL)
                                    : (b != SPX_KEY_EVEN && b != SPX_KEY_ODD))) begin
                        n_phase = PH_IDLE;
                    end else begin
                        n_word = merged;
                        n_left = r_left - 8'd1;
                        if (lane == 3'd7 || r_left == 8'd1) begin
                            key_write = 1'b1;
                        end
                        if (r_left == 8'd1) begin
                            key_done  = 1'b1;
                            n_wr_bank = !r_wr_bank;
                            n_phase   = PH_IDLE;
                        end
                    end
                end
                PH_IDLE: begin
                    n_phase = PH_IDLE;
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
            // end of script returns the parser to its start
            if (i_byte_if.end_of_script) begin
                n_phase    = PH_SIG_OP;
                n_left     = 8'd0;
                n_sig_len  = 8'd0;
                n_key_long = 1'b0;
            end
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_SIG_OP;
            r_left     <= 8'd0;
            r_sig_len  <= 8'd0;
            r_key_long <= 1'b0;
            r_wr_bank  <= 1'b0;
        end else begin
            r_phase    <= n_phase;
            r_left     <= n_left;
            r_sig_len  <= n_sig_len;
            r_key_long <= n_key_long;
            r_wr_bank  <= n_wr_bank;
        end
    end

    // word assembly register
    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    // key store write and hand-off to the emitter
    always_comb begin
        o_wr.en         = key_write;
        o_wr.addr       = {r_wr_bank, key_pos[6:3]};
        o_wr.data       = merged;
        o_done.valid    = key_done;
        o_done.bank     = r_wr_bank;
        o_done.long_key = r_key_long;
    end
endmodule
`default_nettype wire

[sv/spx_emitter.sv]
// key chunk emitter: reads finished keys from the key store into an output queue
`default_nettype none
module spx_emitter (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire spx_pkg::t_key_done              i_done,
    input  wire logic [spx_pkg::SPX_WORD_W-1:0]  i_rdata,
    output logic                                 o_re,
    output logic [spx_pkg::SPX_ADDR_W-1:0]       o_raddr,
    output spx_pkg::t_em_status                  o_status,
    spx_chunk_if.source                          o_chunk_if
);
    import spx_pkg::*;

    // current and pending key
    logic       r_busy, n_busy;
    logic       r_bank, n_bank;
    logic       r_long, n_long;
    logic [3:0] r_idx, n_idx;
    logic       r_pend, n_pend;
    logic       r_pend_bank, n_pend_bank;
    logic       r_pend_long, n_pend_long;

    // read in flight
    logic       r_fl_valid;
    logic [3:0] r_fl_bytes;
    logic       r_fl_last;
    logic [6:0] r_fl_len;

    // two entry output queue
    t_chunk     r_q [2];
    logic       r_q_rd, r_q_wr;
    logic [1:0] r_count;

    logic [2:0] occ;
    logic       pop;
    logic       issue;
    logic       is_last;
    logic       free_next;
    t_chunk     push_item;

    assign occ     = {1'b0, r_count} + {2'd0, r_fl_valid};
    assign pop     = o_chunk_if.valid && o_chunk_if.ready;
    assign issue   = r_busy && ((occ < 3'd2) || (occ == 3'd2 && pop));
    assign is_last = (r_idx == (r_long ? SPX_LAST_LONG : SPX_LAST_SHORT));
    assign free_next = !r_busy || (issue && is_last);

    assign o_re    = issue;
    assign o_raddr = {r_bank, r_idx};

    assign o_status.hold = r_pend;
    assign o_status.busy = r_busy;

    // read sequencing and pending key hand-over
    always_comb begin
        n_busy      = r_busy;
        n_bank      = r_bank;
        n_long      = r_long;
        n_idx       = r_idx;
        n_pend      = r_pend;
        n_pend_bank = r_pend_bank;
        n_pend_long = r_pend_long;
        if (issue) begin
            n_idx = r_idx + 4'd1;
            if (is_last) begin
                if (r_pend) begin
                    n_bank = r_pend_bank;
                    n_long = r_pend_long;
                    n_idx  = 4'd0;
                    n_pend = 1'b0;
                end else begin
                    n_busy = 1'b0;
                end
            end
        end
        if (i_done.valid) begin
            if (free_next && !r_pend) begin
                n_busy = 1'b1;
                n_bank = i_done.bank;
                n_long = i_done.long_key;
                n_idx  = 4'd0;
            end else begin
                n_pend      = 1'b1;
                n_pend_bank = i_done.bank;
                n_pend_long = i_done.long_key;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b0;
            r_pend     <= 1'b0;
            r_fl_valid <= 1'b0;
            r_q_rd     <= 1'b0;
            r_q_wr     <= 1'b0;
            r_count    <= 2'd0;
        end else begin
            r_busy     <= n_busy;
            r_pend     <= n_pend;
            r_fl_valid <= issue;
            if (r_fl_valid) begin
                r_q_wr <= !r_q_wr;
            end
            if (pop) begin
                r_q_rd <= !r_q_rd;
            end
            r_count <= r_count + {1'b0, r_fl_valid} - {1'b0, pop};
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_bank      <= n_bank;
        r_long      <= n_long;
        r_idx       <= n_idx;
        r_pend_bank <= n_pend_bank;
        r_pend_long <= n_pend_long;
        if (issue) begin
            r_fl_bytes <= is_last ? SPX_TAIL_CHUNK : SPX_FULL_CHUNK;
            r_fl_last  <= is_last;
            r_fl_len   <= r_long ? SPX_KEY_LONG[6:0] : SPX_KEY_SHORT[6:0];
        end
        if (r_fl_valid) begin
            r_q[r_q_wr] <= push_item;
        end
    end

    // item pushed into the queue when read data returns
    always_comb begin
        push_item.key_chunk   = i_rdata;
        push_item.chunk_bytes = r_fl_bytes;
        push_item.last_chunk  = r_fl_last;
        push_item.key_length  = r_fl_len;
    end

    // queue head drives the output channel
    assign o_chunk_if.valid       = (r_count != 2'd0);
    assign o_chunk_if.key_chunk   = r_q[r_q_rd].key_chunk;
    assign o_chunk_if.chunk_bytes = r_q[r_q_rd].chunk_bytes;
    assign o_chunk_if.last_chunk  = r_q[r_q_rd].last_chunk;
    assign o_chunk_if.key_length  = r_q[r_q_rd].key_length;
endmodule
`default_nettype wire

[sv/scriptsig_pubkey_extractor_top.sv]
// top level of the script signature / public key extractor
//
//  channel      dir  handshake     payload
//  i_byte_if    in   valid/ready   script_byte[7:0], end_of_script
//  o_chunk_if   out  valid/ready   key_chunk[63:0], chunk_bytes[3:0], last_chunk,
//                                  key_length[6:0]
//
//  one script byte is taken every cycle unless held; parser state is in registers
//  and key words go into a two bank key store ram (one write, one read port)
//  a finished key is read back one word a cycle unless the output queue is full:
//  5 or 9 chunks, each through the registered ram read and a two item queue
//  input stalls only while a second finished key waits for the bank being read
//  reset is synchronous active low and leaves the parser expecting the
//  signature push; no clearing pass, the key store is never read unwritten
`default_nettype none
module scriptsig_pubkey_extractor_top (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    spx_byte_if.sink    i_byte_if,
    spx_chunk_if.source o_chunk_if
);
    import spx_pkg::*;

    t_wr_req                 wr;
    t_key_done               done;
    t_em_status              em_status;
    logic                    rd_en;
    logic [SPX_ADDR_W-1:0]   rd_addr;
    logic [SPX_WORD_W-1:0]   rd_data;

    // byte parser and key word assembly
    spx_parser u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_byte_if (i_byte_if),
        .i_hold    (em_status.hold),
        .o_wr      (wr),
        .o_done    (done)
    );

    // key store
    spx_ram #(
        .WIDTH (SPX_WORD_W),
        .DEPTH (SPX_RAM_DEPTH)
    ) u_key_store (
        .i_clk   (i_clk),
        .i_we    (wr.en),
        .i_waddr (wr.addr),
        .i_wdata (wr.data),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    // chunk emitter
    spx_emitter u_emitter (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_done     (done),
        .i_rdata    (rd_data),
        .o_re       (rd_en),
        .o_raddr    (rd_addr),
        .o_status   (em_status),
        .o_chunk_if (o_chunk_if)
    );

    // writer and reader never touch the same key store entry in one cycle
    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(wr.en && rd_en && wr.addr == rd_addr))
        else $error("key store write and read hit the same entry");

    // a waiting key implies a key is being read out
    a_hold_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        em_status.hold |-> em_status.busy)
        else $error("pending key without active emission");

    // a finished key never arrives while another one still waits
    a_no_double_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        em_status.hold |-> !done.valid)
        else $error("key completed while the pending slot was full");

    // chunk size agrees with the last chunk flag
    a_chunk_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_chunk_if.valid |->
            ((o_chunk_if.last_chunk && o_chunk_if.chunk_bytes == SPX_TAIL_CHUNK) ||
             (!o_chunk_if.last_chunk && o_chunk_if.chunk_bytes == SPX_FULL_CHUNK)))
        else $error("chunk size does not match last chunk flag");
endmodule
`default_nettype wire
